### sv/kst_pkg.sv
package kst_pkg;

	localparam int KEY_W        = 32;
	localparam int CMD_W        = 2;
	localparam int COUNT_W      = 7;
	localparam int CAPACITY_DEF = 64;

	// Stream packing: input tdata and output tdata widths, padded to whole bytes
	localparam int S_TDATA_W = ((CMD_W + KEY_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((2 + COUNT_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_ADD      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CONTAINS = 2'd2;

	// Token and running flags handed from one cell to the next
	typedef struct packed {
		logic tok;
		logic hit;
		logic free;
	} link_t;

	// Operation broadcast to every cell
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [KEY_W-1:0] key;
		logic             commit;
	} bcast_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_HOLD
	} state_t;

endpackage

### sv/kst_cell.sv
module kst_cell import kst_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  link_t  prev,
	input  bcast_t bc,
	output link_t  next
);

	logic             valid_q;
	logic             cand_q;
	logic [KEY_W-1:0] key_q;
	link_t            next_q;
	logic             match;

	assign match = valid_q && (key_q == bc.key);
	assign next  = next_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cand_q  <= 1'b0;
			next_q  <= '0;
		end else begin
			next_q.tok <= prev.tok;
			if (prev.tok) begin
				next_q.hit  <= prev.hit | match;
				next_q.free <= prev.free | !valid_q;
				// first free cell along the chain becomes the add candidate
				cand_q      <= !prev.free && !valid_q;
				if (bc.cmd == CMD_REMOVE && match) begin
					valid_q <= 1'b0;
				end
			end
			if (bc.commit && cand_q) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (bc.commit && cand_q) begin
			key_q <= bc.key;
		end
	end

endmodule

### sv/kst_ctrl.sv
module kst_ctrl import kst_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CMD_W-1:0]   in_command,
	input  logic [KEY_W-1:0]   in_key,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               out_was_present,
	output logic               out_full_drop,
	output logic [COUNT_W-1:0] out_entry_count,
	output link_t              head,
	input  link_t              tail,
	output bcast_t             bc
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t             state_q, state_d;
	logic [CMD_W-1:0]   cmd_q;
	logic [KEY_W-1:0]   key_q;
	logic               head_tok_q;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               m_valid_q;
	logic               present_q, drop_q;
	logic [COUNT_W-1:0] count_q;
	logic               pend_present_q, pend_drop_q;

	logic accept, done, out_free, commit, drop, load_out, load_pend;
	logic res_present, res_drop;

	assign in_ready        = (state_q == ST_IDLE);
	assign accept          = in_valid && in_ready;
	assign out_free        = !m_valid_q || out_ready;
	assign done            = (state_q == ST_WALK) && tail.tok;
	assign commit          = done && (cmd_q == CMD_ADD) && !tail.hit && tail.free;
	assign drop            = done && (cmd_q == CMD_ADD) && !tail.hit && !tail.free;

	assign head.tok        = head_tok_q;
	assign head.hit        = 1'b0;
	assign head.free       = 1'b0;
	assign bc.cmd          = cmd_q;
	assign bc.key          = key_q;
	assign bc.commit       = commit;

	assign out_valid       = m_valid_q;
	assign out_was_present = present_q;
	assign out_full_drop   = drop_q;
	assign out_entry_count = count_q;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		load_out    = 1'b0;
		load_pend   = 1'b0;
		res_present = pend_present_q;
		res_drop    = pend_drop_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				res_present = tail.hit;
				res_drop    = drop;
				if (done) begin
					if (commit) begin
						cnt_d = cnt_q + CNT_W'(1);
					end else if (cmd_q == CMD_REMOVE && tail.hit) begin
						cnt_d = cnt_q - CNT_W'(1);
					end
					if (out_free) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						load_pend = 1'b1;
						state_d   = ST_HOLD;
					end
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_tok_q <= 1'b0;
			cnt_q      <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_tok_q <= accept;
			cnt_q      <= cnt_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (out_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_command;
			key_q <= in_key;
		end
		if (load_pend) begin
			pend_present_q <= tail.hit;
			pend_drop_q    <= drop;
		end
		if (load_out) begin
			present_q <= res_present;
			drop_q    <= res_drop;
			count_q   <= COUNT_W'(cnt_d);
		end
	end

endmodule

### sv/key_set_table.sv
// key_set_table: a set of 32-bit keys held in a chain of CAPACITY cells.
//
// Input channel s_*: one transaction is one operation, command plus key.
// Commands: add (store the key in the lowest free cell if not already held),
// remove (clear the cell holding the key), contains (report only). The
// unused fourth code behaves as contains.
// Output channel m_*: exactly one transaction per operation, carrying
// was_present, full_drop and the entry count after the operation.
//
// Each cell holds one key and its valid mark. An accepted operation sends a
// token down the chain, one cell per cycle; the token collects the hit flag
// and picks the first free cell. At the chain tail the add is committed to
// the picked cell by a broadcast write. The result is registered once the
// token reaches the chain tail, and no new operation is taken before the
// result of the last one has gone into the output register.
//
// Reset clears every valid mark and the count; no clearing pass is needed.
// When the receiver stalls, hold the result in the output register; a
// second finished result waits in a one-entry holding register, and the
// input side stops taking transactions until it has moved on.
module key_set_table import kst_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // [1:0] command, [33:2] key, rest zero
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // [0] was_present, [1] full_drop,
	                                        // [8:2] entry_count, rest zero
);

	link_t  links [CAPACITY+1];
	bcast_t bc;

	logic               was_present;
	logic               full_drop;
	logic [COUNT_W-1:0] entry_count;

	kst_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_command      (s_tdata[CMD_W-1:0]),
		.in_key          (s_tdata[CMD_W+KEY_W-1:CMD_W]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_was_present (was_present),
		.out_full_drop   (full_drop),
		.out_entry_count (entry_count),
		.head            (links[0]),
		.tail            (links[CAPACITY]),
		.bc              (bc)
	);

	// Chain of key cells: each hands the token and running flags to the next
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		kst_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.prev   (links[i]),
			.bc     (bc),
			.next   (links[i+1])
		);
	end

	// Pack the result fields from the lowest bit up, pad with zeros
	assign m_tdata = {(M_TDATA_W - COUNT_W - 2)'(0), entry_count, full_drop, was_present};

endmodule

### sv/kst_checker.sv
module kst_checker import kst_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or dropped while stalled");

	// One operation at a time: busy right after an input transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an operation is in flight");

	// A held key is never dropped
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("was_present and full_drop both set");

	// A full drop reports a full table
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[COUNT_W+1:2] == COUNT_W'(CAPACITY))
		else $error("full drop with a table that is not full");

endmodule

bind key_set_table kst_checker #(.CAPACITY(CAPACITY)) u_kst_checker (.*);
